FILE: rtl/rfa_pkg.sv
`timescale 1ns / 1ps

package rfa_pkg;

  // Position of the byte that the sequencer is working on within one item.
  localparam int unsigned SlotW = 4;

  localparam logic [SlotW-1:0] SLOT_HDR_FIRST = 4'd0;
  localparam logic [SlotW-1:0] SLOT_HDR_LAST  = 4'd7;
  localparam logic [SlotW-1:0] SLOT_PAYLOAD   = 4'd8;
  localparam logic [SlotW-1:0] SLOT_SUM       = 4'd9;
  localparam logic [SlotW-1:0] SLOT_TAIL0     = 4'd10;
  localparam logic [SlotW-1:0] SLOT_TAIL1     = 4'd11;

  // Fixed frame bytes.
  localparam logic [7:0] BYTE_LEAD     = 8'hCC;
  localparam logic [7:0] BYTE_PREAMBLE = 8'hAA;
  localparam logic [7:0] BYTE_SYNC0    = 8'h2D;
  localparam logic [7:0] BYTE_SYNC1    = 8'hD4;
  localparam logic [7:0] BYTE_TAIL0    = 8'h40;
  localparam logic [7:0] BYTE_TAIL1    = 8'h00;

  // Register index of the configuration space.
  localparam logic REG_CHECKSUM_ENABLE = 1'b0;

  // One frame byte handed from the sequencer to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_end;
  } rfa_emit_t;

  // Header byte at a given position: lead-in, preamble, then sync word.
  function automatic logic [7:0] header_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0, 3'd1, 3'd2: b = BYTE_LEAD;
      3'd3, 3'd4, 3'd5: b = BYTE_PREAMBLE;
      3'd6:             b = BYTE_SYNC0;
      default:          b = BYTE_SYNC1;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/rfa_cfg_regs.sv
`timescale 1ns / 1ps

module rfa_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        checksum_enable_o
);

  logic checksum_enable_q;
  logic checksum_enable_d;
  logic wr_en;

  assign pready = 1'b1;

  // Only the checksum enable register exists; other writes are ignored.
  assign wr_en = psel && penable && pwrite && (paddr[2] == rfa_pkg::REG_CHECKSUM_ENABLE);

  always_comb begin
    checksum_enable_d = checksum_enable_q;
    if (wr_en) begin
      checksum_enable_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      checksum_enable_q <= 1'b1;
    end else begin
      checksum_enable_q <= checksum_enable_d;
    end
  end

  // Read data for the addressed register.
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == rfa_pkg::REG_CHECKSUM_ENABLE) begin
      prdata = {31'd0, checksum_enable_q};
    end
  end

  assign checksum_enable_o = checksum_enable_q;

endmodule

FILE: rtl/rfa_sequencer.sv
`timescale 1ns / 1ps

module rfa_sequencer #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              checksum_enable_i,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [7:0]        s_byte_i,
  input  logic              s_last_i,
  input  logic              out_free_i,
  output rfa_pkg::rfa_emit_t emit_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);

  // Input register and slot position of the item in work.
  logic                      busy_q, busy_d;
  logic [7:0]                byte_q, byte_d;
  logic                      last_q, last_d;
  logic [rfa_pkg::SlotW-1:0] slot_q, slot_d;

  // Frame state.
  logic                      in_frame_q, in_frame_d;
  logic [7:0]                sum_q, sum_d;
  logic [CntW-1:0]           count_q, count_d;

  logic                      drop;
  logic                      can_step;
  logic                      is_final;
  logic                      item_done;
  logic                      emit_en;
  logic                      accept;
  logic [rfa_pkg::SlotW-1:0] slot_next;
  logic [7:0]                cur_byte;

  // Once the byte budget is used up every remaining byte of the item is dropped.
  assign drop      = !(count_q < CntMax);
  assign can_step  = busy_q && (drop || out_free_i);
  assign is_final  = ((slot_q == rfa_pkg::SLOT_PAYLOAD) && !last_q) ||
                     (slot_q == rfa_pkg::SLOT_TAIL1);
  assign item_done = can_step && (is_final || drop);
  assign emit_en   = can_step && !drop;

  assign s_tready_o = !busy_q || item_done;
  assign accept     = s_tvalid_i && s_tready_o;

  // Slot order: header, payload, optional sum, then the two tail bytes.
  always_comb begin
    slot_next = slot_q;
    if (slot_q < rfa_pkg::SLOT_HDR_LAST) begin
      slot_next = slot_q + rfa_pkg::SlotW'(1);
    end else if (slot_q == rfa_pkg::SLOT_HDR_LAST) begin
      slot_next = rfa_pkg::SLOT_PAYLOAD;
    end else if (slot_q == rfa_pkg::SLOT_PAYLOAD) begin
      slot_next = checksum_enable_i ? rfa_pkg::SLOT_SUM : rfa_pkg::SLOT_TAIL0;
    end else if (slot_q == rfa_pkg::SLOT_SUM) begin
      slot_next = rfa_pkg::SLOT_TAIL0;
    end else if (slot_q == rfa_pkg::SLOT_TAIL0) begin
      slot_next = rfa_pkg::SLOT_TAIL1;
    end
  end

  // Byte for the current slot.
  always_comb begin
    if (slot_q <= rfa_pkg::SLOT_HDR_LAST) begin
      cur_byte = rfa_pkg::header_byte(slot_q[2:0]);
    end else if (slot_q == rfa_pkg::SLOT_PAYLOAD) begin
      cur_byte = byte_q;
    end else if (slot_q == rfa_pkg::SLOT_SUM) begin
      cur_byte = sum_q;
    end else if (slot_q == rfa_pkg::SLOT_TAIL0) begin
      cur_byte = rfa_pkg::BYTE_TAIL0;
    end else begin
      cur_byte = rfa_pkg::BYTE_TAIL1;
    end
  end

  // Result towards the output register. The run ends on the item's final slot
  // or on the byte that uses up the budget.
  always_comb begin
    emit_o.valid      = emit_en;
    emit_o.frame_byte = cur_byte;
    emit_o.run_last   = is_final || ((count_q + CntW'(1)) == CntMax);
    emit_o.frame_end  = (slot_q == rfa_pkg::SLOT_TAIL1);
  end

  // Next state. The step of the current item is applied first, so that an item
  // accepted in the same cycle sees a frame that has just been closed.
  always_comb begin
    busy_d     = busy_q;
    byte_d     = byte_q;
    last_d     = last_q;
    slot_d     = slot_q;
    in_frame_d = in_frame_q;
    sum_d      = sum_q;
    count_d    = count_q;

    if (can_step && (slot_q == rfa_pkg::SLOT_PAYLOAD)) begin
      sum_d = sum_q + byte_q;
    end
    if (emit_en) begin
      count_d = count_q + CntW'(1);
    end
    if (can_step && !item_done) begin
      slot_d = slot_next;
    end
    if (item_done) begin
      busy_d = 1'b0;
      if (last_q) begin
        in_frame_d = 1'b0;
        sum_d      = 8'd0;
        count_d    = '0;
      end
    end

    // A closed frame already holds zero sum and count, so a new one just opens.
    if (accept) begin
      busy_d     = 1'b1;
      byte_d     = s_byte_i;
      last_d     = s_last_i;
      slot_d     = in_frame_d ? rfa_pkg::SLOT_PAYLOAD : rfa_pkg::SLOT_HDR_FIRST;
      in_frame_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      slot_q     <= rfa_pkg::SLOT_HDR_FIRST;
      in_frame_q <= 1'b0;
      sum_q      <= 8'd0;
      count_q    <= '0;
    end else begin
      busy_q     <= busy_d;
      slot_q     <= slot_d;
      in_frame_q <= in_frame_d;
      sum_q      <= sum_d;
      count_q    <= count_d;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

endmodule

FILE: rtl/rfa_out_reg.sv
`timescale 1ns / 1ps

module rfa_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfa_pkg::rfa_emit_t emit_i,
  output logic               out_free_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic               m_axis_tlast,
  output logic               m_axis_tuser
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic       user_q, user_d;

  // The register takes a new item when empty or when its item leaves now.
  assign out_free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    user_d  = user_q;
    if (out_free_o) begin
      valid_d = emit_i.valid;
      data_d  = emit_i.frame_byte;
      last_d  = emit_i.run_last;
      user_d  = emit_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    user_q <= user_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = user_q;

endmodule

FILE: rtl/rf_frame_assembler_core.sv
`timescale 1ns / 1ps

// Radio frame assembler. Payload bytes enter on the slave stream, with tlast
// on the final byte of a frame, and the frame leaves one byte per cycle on the
// master stream: the header CC CC CC AA AA AA 2D D4 before the first payload
// byte, the payload itself, the 8-bit wrapping payload sum when checksum_enable
// is set, and the tail 40 00, whose final byte carries tuser. The master tlast
// marks the last byte produced for each input item. A frame is cut off after
// MAX_FRAME_BYTES bytes; later bytes are dropped while the sum still covers
// every payload byte. Mid-frame, payload bytes flow at one per cycle while
// the master side takes every byte. The sequencer takes a new input item only
// once it is idle or finishing the last one, and hands one frame byte per
// cycle to the output register while that register is free.
module rf_frame_assembler_core #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Payload input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
  input  logic        s_axis_tlast,   // last_payload
  // Frame output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // [0] frame_end
);

  logic               checksum_enable;
  logic               out_free;
  rfa_pkg::rfa_emit_t emit;

  rfa_cfg_regs u_cfg_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .checksum_enable_o (checksum_enable)
  );

  rfa_sequencer #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_sequencer (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .checksum_enable_i (checksum_enable),
    .s_tvalid_i        (s_axis_tvalid),
    .s_tready_o        (s_axis_tready),
    .s_byte_i          (s_axis_tdata),
    .s_last_i          (s_axis_tlast),
    .out_free_i        (out_free),
    .emit_o            (emit)
  );

  rfa_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit),
    .out_free_o    (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: verif/rfa_frame_book_pkg.sv
`timescale 1ns / 1ps

package rfa_frame_book_pkg;

  // One byte of the frame as it should appear on the air.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_end;
  } air_byte_t;

  // Scoreboard: a shadow framer that turns each accepted payload item into
  // the frame bytes it must cause, and a queue of those bytes in order.
  class frame_book;
    int unsigned max_bytes;
    logic        sum_on;
    logic        open;
    logic [7:0]  sum;
    int unsigned emitted;
    int unsigned mismatches;
    air_byte_t   burst[$];
    air_byte_t   awaited_q[$];

    function new(int unsigned max_frame_bytes);
      max_bytes  = max_frame_bytes;
      sum_on     = 1'b1;
      open       = 1'b0;
      sum        = 8'h00;
      emitted    = 0;
      mismatches = 0;
    endfunction

    function void set_checksum(logic en);
      sum_on = en;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH: %s", what);
      end
    endfunction

    // Bytes past the frame size limit never reach the air.
    function void stage(logic [7:0] b, logic is_end);
      if (emitted >= max_bytes) begin
        return;
      end
      emitted++;
      burst.push_back('{frame_byte: b, run_last: 1'b0, frame_end: is_end});
    endfunction

    // Work out the frame bytes caused by one accepted payload item.
    function void note_payload(logic [7:0] b, logic last);
      logic [7:0] hdr [8];
      hdr = '{rfa_pkg::BYTE_LEAD, rfa_pkg::BYTE_LEAD, rfa_pkg::BYTE_LEAD,
              rfa_pkg::BYTE_PREAMBLE, rfa_pkg::BYTE_PREAMBLE, rfa_pkg::BYTE_PREAMBLE,
              rfa_pkg::BYTE_SYNC0, rfa_pkg::BYTE_SYNC1};
      burst.delete();
      if (!open) begin
        open    = 1'b1;
        sum     = 8'h00;
        emitted = 0;
        foreach (hdr[i]) stage(hdr[i], 1'b0);
      end
      stage(b, 1'b0);
      sum = sum + b;
      if (last) begin
        if (sum_on) stage(sum, 1'b0);
        stage(rfa_pkg::BYTE_TAIL0, 1'b0);
        stage(rfa_pkg::BYTE_TAIL1, 1'b1);
        open    = 1'b0;
        sum     = 8'h00;
        emitted = 0;
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[i]) awaited_q.push_back(burst[i]);
    endfunction

    // Compare one frame byte taken from the output with the oldest one awaited.
    function void check_byte(logic [7:0] b, logic run_last, logic frame_end);
      air_byte_t want;
      if (awaited_q.size() == 0) begin
        note_mismatch($sformatf("unexpected frame byte %02h tlast %0b tuser %0b",
                                b, run_last, frame_end));
        return;
      end
      want = awaited_q.pop_front();
      if (want.frame_byte !== b || want.run_last !== run_last ||
          want.frame_end !== frame_end) begin
        note_mismatch($sformatf(
            "frame byte exp %02h/%0b/%0b got %02h/%0b/%0b (byte/tlast/tuser)",
            want.frame_byte, want.run_last, want.frame_end, b, run_last, frame_end));
      end
    endfunction
  endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MaxFrameBytes = 64;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned PhaseItems    = 80;
  localparam logic [2:0]  CsAddr        = 3'(4 * int'(rfa_pkg::REG_CHECKSUM_ENABLE));

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] payload_byte
  logic        s_axis_tlast;   // last_payload
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] frame_byte
  logic        m_axis_tlast;   // run_last
  logic        m_axis_tuser;   // [0] frame_end

  rfa_frame_book_pkg::frame_book book;
  logic        calm = 1'b0;
  int unsigned sent_items = 0;

  rf_frame_assembler_core #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Output side: check every accepted frame byte, then pick the next tready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      book.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
  end

  // Offer one payload item, with random idle cycles ahead of it.
  task automatic send_payload(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_payload(b, last);
    sent_items++;
  endtask

  // A run of random payload bytes; the final one closes the frame if asked.
  task automatic send_run(input int unsigned len, input logic closes);
    for (int unsigned k = 0; k < len; k++) begin
      send_payload(8'($urandom_range(0, 255)), closes && (k == len - 1));
    end
  endtask

  // Stop offering items and wait until every awaited frame byte is out.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  // Register write, made only once the block is idle; then read it back.
  task automatic set_checksum_enable(input logic en);
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CsAddr;
    pwdata  <= {31'b0, en};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    book.set_checksum(en);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {31'b0, en}) begin
      book.note_mismatch($sformatf("checksum_enable read exp %08h got %08h",
                                   {31'b0, en}, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly short frames, some mid-sized, a few that run past the size limit.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 40);
    return $urandom_range(50, 72);
  endfunction

  // Run time limit.
  initial begin
    #2_000_000;
    $display("rf_frame_assembler_core test failed");
    $finish;
  end

  // Main sequence.
  initial begin
    int unsigned phase_start;
    int unsigned wait_cycles;
    book          = new(MaxFrameBytes);
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-byte frames at the byte extremes and wrapping sums, then a
    // one-byte and a two-byte frame with the checksum off.
    set_checksum_enable(1'b1);
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b1);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h01, 1'b1);
    send_payload(8'h80, 1'b0);
    send_payload(8'h7F, 1'b0);
    send_payload(8'h55, 1'b0);
    send_payload(8'hAA, 1'b1);
    set_checksum_enable(1'b0);
    send_payload(8'h5A, 1'b1);
    send_payload(8'h00, 1'b0);
    send_payload(8'hFF, 1'b1);

    // Random phases, each under its own checksum setting.
    for (int ph = 0; ph < 4; ph++) begin
      set_checksum_enable(ph == 0 ? 1'b1 : ph == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      calm = (ph == 2);
      phase_start = sent_items;
      if (ph == 0) begin
        // Hold the input mid-frame until the output has fully caught up.
        send_run(5, 1'b0);
        pause_until_drained();
        send_run(4, 1'b1);
      end
      while (sent_items - phase_start < PhaseItems) send_run(pick_len(), 1'b1);
    end
    calm = 1'b0;

    // Let the output drain, with a bound, then a few quiet cycles.
    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (book.pending() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (book.pending() != 0) begin
      $display("%0d frame bytes never arrived", book.pending());
    end
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("rf_frame_assembler_core test passed");
    end else begin
      $display("rf_frame_assembler_core test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rfa_pkg.sv
rtl/rfa_cfg_regs.sv
rtl/rfa_sequencer.sv
rtl/rfa_out_reg.sv
rtl/rf_frame_assembler_core.sv
verif/rfa_frame_book_pkg.sv
verif/tb_top.sv
